[rtl/jet_pkg.sv]
package jet_pkg;

    // field widths
    localparam int PIX_W     = 10;
    localparam int RAD_W     = 10;
    localparam int MAXIT_W   = 6;
    localparam int CNT_W     = 6;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int FRAC_BITS = 28;

    // window geometry and iteration bound
    localparam int MASK_CENTER = 500;
    localparam int PIXEL_SCALE = 200;
    localparam int ITER_BOUND  = 32;

    // one cell per tested iterate, z0 up to z at the bound
    localparam int NUM_CELLS = ITER_BOUND + 1;

    // register reset values
    localparam logic [MAXIT_W-1:0] RST_MAX_ITER = MAXIT_W'(30);
    localparam logic [COORD_W-1:0] RST_C_REAL   = 32'hF000_0000;
    localparam logic [COORD_W-1:0] RST_C_IMAG   = '0;
    localparam logic [RAD_W-1:0]   RST_RADIUS   = RAD_W'(400);

    // |z|^2 > 4 in Q8.56
    localparam logic [2*COORD_W-1:0] ESC_LIM = 64'd1 << (2 * FRAC_BITS + 2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER    = 2'd0,
        CFG_C_REAL      = 2'd1,
        CFG_C_IMAG      = 2'd2,
        CFG_MASK_RADIUS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             in_disc;
        logic             done;
        logic [CNT_W-1:0] count;
    } t_pix_meta;

    typedef struct packed {
        logic               valid;
        t_pix_meta          meta;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_cell_data;

    // clamp to the signed 32-bit range
    function automatic logic [COORD_W-1:0] sat32(input logic signed [COORD_W+5:0] v);
        logic signed [COORD_W+5:0] hi;
        logic signed [COORD_W+5:0] lo;
        hi = (COORD_W+6)'(64'sh7FFF_FFFF);
        lo = -hi - (COORD_W+6)'(1);
        if (v > hi) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

endpackage

[rtl/jet_front.sv]
module jet_front
    import jet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [PIX_W-1:0]   i_col,
    input  logic [PIX_W-1:0]   i_row,
    input  logic [RAD_W-1:0]   i_radius,
    output t_cell_data         o_d
);

    // start point = trunc(|d| * 2^FRAC / SCALE) split as quotient part and remainder part
    localparam longint QUO   = (64'd1 << FRAC_BITS) / PIXEL_SCALE;
    localparam longint REM   = (64'd1 << FRAC_BITS) % PIXEL_SCALE;
    localparam longint RECIP = ((64'd1 << 32) + PIXEL_SCALE - 1) / PIXEL_SCALE;

    localparam int QUO_W   = FRAC_BITS + 1;
    localparam int P1_W    = PIX_W + QUO_W;
    localparam int V_W     = 2 * PIX_W;
    localparam int RECIP_W = 33;
    localparam int FX_W    = V_W + RECIP_W;
    localparam int SQ_W    = 2 * PIX_W;

    localparam logic [QUO_W-1:0]   QUO_C   = QUO_W'(QUO);
    localparam logic [PIX_W-1:0]   REM_C   = PIX_W'(REM);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [P1_W-1:0]    POS_MAX = P1_W'(64'h7FFF_FFFF);
    localparam logic [P1_W-1:0]    NEG_MAX = P1_W'(64'h8000_0000);

    function automatic logic [COORD_W-1:0] to_coord(input logic neg,
                                                    input logic [P1_W-1:0] q);
        logic [COORD_W-1:0] t;
        t = q[COORD_W-1:0];
        if (!neg) begin
            return (q > POS_MAX) ? POS_MAX[COORD_W-1:0] : t;
        end else begin
            return (q > NEG_MAX) ? NEG_MAX[COORD_W-1:0] : (~t + COORD_W'(1));
        end
    endfunction

    logic signed [PIX_W:0] w_dx;
    logic signed [PIX_W:0] w_dy;
    logic [PIX_W-1:0]      w_ax;
    logic [PIX_W-1:0]      w_ay;

    always_comb begin
        w_dx = $signed({1'b0, i_col}) - $signed((PIX_W+1)'(MASK_CENTER));
        w_dy = $signed({1'b0, i_row}) - $signed((PIX_W+1)'(MASK_CENTER));
        w_ax = w_dx[PIX_W] ? PIX_W'(-w_dx) : PIX_W'(w_dx);
        w_ay = w_dy[PIX_W] ? PIX_W'(-w_dy) : PIX_W'(w_dy);
    end

    // stage 1: products
    logic            r1_valid;
    logic            r1_sx, r1_sy;
    logic [P1_W-1:0] r1_p1x, r1_p1y;
    logic [V_W-1:0]  r1_vx, r1_vy;
    logic [SQ_W-1:0] r1_ax2, r1_ay2, r1_r2;

    // stage 2: disc test and remainder quotient
    logic            r2_valid;
    logic            r2_in_disc;
    logic            r2_sx, r2_sy;
    logic [P1_W-1:0] r2_p1x, r2_p1y;
    logic [FX_W-1:0] r2_fx, r2_fy;

    // stage 3: start point
    logic               r3_valid;
    logic               r3_in_disc;
    logic [COORD_W-1:0] r3_x, r3_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx  <= w_dx[PIX_W];
            r1_sy  <= w_dy[PIX_W];
            r1_p1x <= w_ax * QUO_C;
            r1_p1y <= w_ay * QUO_C;
            r1_vx  <= w_ax * REM_C;
            r1_vy  <= w_ay * REM_C;
            r1_ax2 <= w_ax * w_ax;
            r1_ay2 <= w_ay * w_ay;
            r1_r2  <= i_radius * i_radius;

            r2_in_disc <= ({1'b0, r1_ax2} + {1'b0, r1_ay2}) <= {1'b0, r1_r2};
            r2_sx      <= r1_sx;
            r2_sy      <= r1_sy;
            r2_p1x     <= r1_p1x;
            r2_p1y     <= r1_p1y;
            r2_fx      <= r1_vx * RECIP_C;
            r2_fy      <= r1_vy * RECIP_C;

            r3_in_disc <= r2_in_disc;
            r3_x       <= to_coord(r2_sx, r2_p1x + P1_W'(r2_fx[FX_W-1:32]));
            r3_y       <= to_coord(r2_sy, r2_p1y + P1_W'(r2_fy[FX_W-1:32]));
        end
    end

    always_comb begin
        o_d              = '0;
        o_d.valid        = r3_valid;
        o_d.meta.in_disc = r3_in_disc;
        o_d.meta.done    = 1'b0;
        o_d.meta.count   = '0;
        o_d.x            = r3_x;
        o_d.y            = r3_y;
    end

endmodule

[rtl/jet_cell.sv]
module jet_cell
    import jet_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [CNT_W-1:0]   i_test_iter,
    input  logic [CNT_W-1:0]   i_limit,
    input  logic [COORD_W-1:0] i_c_re,
    input  logic [COORD_W-1:0] i_c_im,
    input  t_cell_data         i_d,
    output t_cell_data         o_d
);

    localparam int P_W  = 2 * COORD_W;
    localparam int RE_W = P_W - FRAC_BITS;
    localparam int IM_W = P_W - FRAC_BITS + 1;
    localparam int S_W  = COORD_W + 6;

    // stage 1: squares and cross product of the incoming iterate
    logic                r1_valid;
    t_pix_meta           r1_meta;
    logic signed [P_W-1:0] r1_xx, r1_yy, r1_xy;

    // stage 2: escape test, shifted terms
    logic                 r2_valid;
    t_pix_meta            r2_meta;
    logic signed [RE_W-1:0] r2_re;
    logic signed [IM_W-1:0] r2_im;

    // stage 3: next iterate
    logic               r3_valid;
    t_pix_meta          r3_meta;
    logic [COORD_W-1:0] r3_x, r3_y;

    logic                 w_hit;
    logic [P_W-1:0]       w_mag;
    logic signed [P_W-1:0] w_diff;
    t_pix_meta            n_meta;

    always_comb begin
        w_mag  = r1_xx + r1_yy;
        w_diff = r1_xx - r1_yy;
        w_hit  = r1_meta.in_disc && !r1_meta.done && (i_test_iter != '0)
                 && (i_test_iter <= i_limit) && (w_mag > ESC_LIM);
        n_meta = r1_meta;
        if (w_hit) begin
            n_meta.done  = 1'b1;
            n_meta.count = i_test_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_d.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_meta <= i_d.meta;
            r1_xx   <= $signed(i_d.x) * $signed(i_d.x);
            r1_yy   <= $signed(i_d.y) * $signed(i_d.y);
            r1_xy   <= $signed(i_d.x) * $signed(i_d.y);

            r2_meta <= n_meta;
            r2_re   <= w_diff[P_W-1:FRAC_BITS];
            r2_im   <= r1_xy[P_W-1:FRAC_BITS-1];

            r3_meta <= r2_meta;
            r3_x    <= sat32(S_W'(r2_re) + S_W'($signed(i_c_re)));
            r3_y    <= sat32(S_W'(r2_im) + S_W'($signed(i_c_im)));
        end
    end

    always_comb begin
        o_d       = '0;
        o_d.valid = r3_valid;
        o_d.meta  = r3_meta;
        o_d.x     = r3_x;
        o_d.y     = r3_y;
    end

endmodule

[rtl/julia_escape_time_pixel.sv]
// julia set escape-time classifier, one pixel item per input handshake
//
// input channel: i_in_valid / o_in_ready carry (pixel_col, pixel_row). output channel:
// o_out_valid / i_out_ready carry in_mask, escaped, escape_count and odd_escape, one
// result item per pixel, in input order. config channel: i_cfg_valid / o_cfg_ready
// with i_cfg_index and i_cfg_data, always ready; write only while the block is idle.
//
// from input accept to o_out_valid an item passes three front-end stages (disc test
// and start point), then a chain of 33 iteration cells of three stages each, one cell
// per tested iterate, then the output register. throughput is one item per cycle unless
// the receiver stalls, set by the three 32x32 multipliers in each cell's first stage.
//
// the whole chain moves as one: it advances when the output register is empty or
// being taken. while the receiver stalls with a result held, o_in_ready is low and
// every stage holds its item. reset clears all valid bits and loads the register
// defaults (limit 30, c = -1 + 0i, radius 400); no items are in flight afterwards.
module julia_escape_time_pixel
    import jet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel_col,
    input  logic [PIX_W-1:0]     i_pixel_row,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_mask,
    output logic                 o_escaped,
    output logic [CNT_W-1:0]     o_escape_count,
    output logic                 o_odd_escape,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration registers
    logic [MAXIT_W-1:0] r_max_iter;
    logic [COORD_W-1:0] r_c_re;
    logic [COORD_W-1:0] r_c_im;
    logic [RAD_W-1:0]   r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RST_MAX_ITER;
            r_c_re     <= RST_C_REAL;
            r_c_im     <= RST_C_IMAG;
            r_radius   <= RST_RADIUS;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_ITER:    r_max_iter <= i_cfg_data[MAXIT_W-1:0];
                CFG_C_REAL:      r_c_re     <= i_cfg_data[COORD_W-1:0];
                CFG_C_IMAG:      r_c_im     <= i_cfg_data[COORD_W-1:0];
                CFG_MASK_RADIUS: r_radius   <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // iteration limit clamped to the iteration bound
    logic [CNT_W-1:0] w_limit;
    assign w_limit = (r_max_iter > MAXIT_W'(ITER_BOUND)) ? CNT_W'(ITER_BOUND)
                                                          : CNT_W'(r_max_iter);

    // global advance: output slot free or being drained
    logic r_out_valid;
    logic w_en;
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    t_cell_data w_chain [NUM_CELLS+1];

    jet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_col    (i_pixel_col),
        .i_row    (i_pixel_row),
        .i_radius (r_radius),
        .o_d      (w_chain[0])
    );

    // cell k tests iterate z_k and produces z_(k+1)
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        jet_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_en),
            .i_test_iter (CNT_W'(k)),
            .i_limit     (w_limit),
            .i_c_re      (r_c_re),
            .i_c_im      (r_c_im),
            .i_d         (w_chain[k]),
            .o_d         (w_chain[k+1])
        );
    end

    // output register
    t_pix_meta r_out_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_chain[NUM_CELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_meta <= w_chain[NUM_CELLS].meta;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_in_mask      = r_out_meta.in_disc;
    assign o_escaped      = r_out_meta.done;
    assign o_escape_count = r_out_meta.count;
    assign o_odd_escape   = r_out_meta.count[0];

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // escape flag and count agree
    a_count_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_escaped == (o_escape_count != '0)))
        else $error("escape flag and count disagree");

    // only pixels inside the disc can escape
    a_escape_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_escaped) |-> o_in_mask)
        else $error("escape reported for masked pixel");

    // count never passes the iteration bound
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_escape_count <= CNT_W'(ITER_BOUND)))
        else $error("escape count beyond bound");

    // a stalled result blocks intake and is still there next cycle
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(r_out_meta)))
        else $error("held result changed under stall");

endmodule
